// File: rtl/gb5_pkg.sv
// Shared types and constants for the 5x5 lower-region blur.
// No dependencies.
package gb5_pkg;
	localparam int NUM_REGS = 8;
	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_C0     = 3'd2;
	localparam logic [2:0] REG_C1     = 3'd3;
	localparam logic [2:0] REG_C2     = 3'd4;
	localparam logic [2:0] REG_C3     = 3'd5;
	localparam logic [2:0] REG_C4     = 3'd6;
	localparam logic [2:0] REG_C5     = 3'd7;
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	// control that travels down the pipeline with each item
	typedef struct packed {
		logic       vld;
		logic       blur;
		logic       border;
		logic       last;
	} ctl_t;

	// class of tap (r,c) in the 5x5 window
	function automatic logic [2:0] tap_class(input int r, input int c);
		int dr, dc;
		dr = (r >= 2) ? r - 2 : 2 - r;
		dc = (c >= 2) ? c - 2 : 2 - c;
		if (dr > dc) begin
			dr = dr + dc; dc = dr - dc; dr = dr - dc;
		end
		if (dr == 0 && dc == 0) return 3'd0;
		if (dr == 0 && dc == 1) return 3'd1;
		if (dr == 1 && dc == 1) return 3'd2;
		if (dr == 0 && dc == 2) return 3'd3;
		if (dr == 1 && dc == 2) return 3'd4;
		return 3'd5;
	endfunction
endpackage

// File: rtl/gb5_ram.sv
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module gb5_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/gb5_cell.sv
// One tap cell of the window chain: holds a pixel, multiplies it by a weight.
// Depends on gb5_pkg.
module gb5_cell import gb5_pkg::*; #(
	parameter int CB = 16
) (
	input  logic              clk,
	input  logic              en,
	input  logic              shift,
	input  logic [4*CB-1:0]   pix_in,
	output logic [4*CB-1:0]   pix_q,
	input  logic [15:0]       coef,
	output logic [3*(CB+16)-1:0] prod_s1
);
	always_ff @(posedge clk) begin
		if (en && shift) pix_q <= pix_in;
	end
	// products of the current tap; registered once
	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++)
				prod_s1[ch*(CB+16) +: CB+16] <= pix_q[ch*CB +: CB] * coef;
		end
	end
endmodule

// File: rtl/gaussian_blur_5x5_lower_region_core.sv
// Streaming 5x5 blur of the lower frame region; one item per cycle while the output is not stalled.
// Frame delay: 2*W+2 accepted items, then the result passes through the stage registers to the output.
// Throughput: one item per clock while the output is not stalled; set by the line store port (one read, one write).
// Reset clears counters, window valid pipeline and registers to defaults.
// Line store contents are undefined after reset.
// Depends on gb5_pkg, gb5_ram, gb5_cell.
module gaussian_blur_5x5_lower_region_core import gb5_pkg::*; #(
	parameter int MAX_WIDTH    = 1024,
	parameter int CHANNEL_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [15:0] in_red,
	input  logic [15:0] in_green,
	input  logic [15:0] in_blue,
	input  logic [15:0] in_alpha,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] out_red,
	output logic [15:0] out_green,
	output logic [15:0] out_blue,
	output logic [15:0] out_alpha,
	output logic        last_pixel
);
	localparam int CB = CHANNEL_BITS;
	localparam int PW = 4 * CB;
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PB = CB + 16;
	localparam int SB = PB + 5;
	localparam logic [CB-1:0] CMAX = {CB{1'b1}};

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [15:0] coef_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd640; height_q <= 13'd480;
			coef_q[0] <= 16'd2837; coef_q[1] <= 16'd2780; coef_q[2] <= 16'd2725;
			coef_q[3] <= 16'd2618; coef_q[4] <= 16'd2567; coef_q[5] <= 16'd2417;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data[12:0];
				REG_C0: coef_q[0] <= cfg_data;
				REG_C1: coef_q[1] <= cfg_data;
				REG_C2: coef_q[2] <= cfg_data;
				REG_C3: coef_q[3] <= cfg_data;
				REG_C4: coef_q[4] <= cfg_data;
				REG_C5: coef_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [12:0] w_eff, h_eff, blur_row;
	always_comb begin
		w_eff = {2'b0, width_q};
		if (w_eff < 13'd5) w_eff = 13'd5;
		if (w_eff > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
		h_eff = (height_q < 13'd14) ? 13'd14 : height_q;
		blur_row = (h_eff >> 1) - 13'd5;
	end

	// pipeline enable: whole chain advances when the output is free
	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	// input row runs two rows past the frame during the tail
	logic [13:0] irow_q;
	logic [12:0] orow_q;
	logic [12:0] icol_q, ocol_q;
	logic tail, step, valid_now, last_now;
	assign tail = irow_q >= {1'b0, h_eff};
	assign step = in_valid && en && (tail || func == FUNC_PIXEL);
	assign valid_now = irow_q > 14'd2 || (irow_q == 14'd2 && icol_q >= 13'd2);
	assign last_now = (orow_q + 13'd1 >= h_eff) && (ocol_q + 13'd1 >= w_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irow_q <= '0; icol_q <= '0; orow_q <= '0; ocol_q <= '0;
		end else if (step) begin
			if (valid_now && last_now) begin
				irow_q <= '0; icol_q <= '0; orow_q <= '0; ocol_q <= '0;
			end else begin
				if (icol_q + 13'd1 >= w_eff) begin
					icol_q <= '0; irow_q <= irow_q + 14'd1;
				end else icol_q <= icol_q + 13'd1;
				if (valid_now) begin
					if (ocol_q + 13'd1 >= w_eff) begin
						ocol_q <= '0; orow_q <= orow_q + 13'd1;
					end else ocol_q <= ocol_q + 13'd1;
				end
			end
		end
	end

	logic [PW-1:0] pix;
	assign pix = tail ? '0 : {in_alpha[CB-1:0], in_blue[CB-1:0],
		in_green[CB-1:0], in_red[CB-1:0]};

	// four line stores, one per row slot; read this cycle, data next cycle
	logic [AW-1:0] col;
	assign col = icol_q[AW-1:0];
	logic [PW-1:0] rd [4];
	for (genvar k = 0; k < 4; k++) begin : g_ls
		gb5_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_ls (
			.clk(clk), .we(step && irow_q[1:0] == 2'(k)), .waddr(col), .wdata(pix),
			.re(step), .raddr(col), .rdata(rd[k])
		);
	end

	// stage 1: line store data valid; rows aligned by slot
	logic       step_s1;
	logic [1:0] slot_s1;
	logic [PW-1:0] pix_s1;
	ctl_t ctl_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= 1'b0;
			ctl_s1 <= '0;
		end else if (en) begin
			step_s1 <= step;
			ctl_s1.vld <= step && valid_now;
			ctl_s1.blur <= orow_q >= blur_row;
			ctl_s1.border <= ocol_q < 13'd2 || ocol_q + 13'd2 >= w_eff ||
				orow_q < 13'd2 || {1'b0, orow_q} + 14'd2 >= {1'b0, h_eff};
			ctl_s1.last <= last_now;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			slot_s1 <= irow_q[1:0];
			pix_s1 <= pix;
		end
	end
	logic [PW-1:0] v [5];
	always_comb begin
		for (int r = 0; r < 4; r++) v[r] = rd[2'(slot_s1 + 2'(r))];
		v[4] = pix_s1;
	end

	// window chain: each row shifts one cell per item
	logic [PW-1:0] win [5][5];
	logic [3*PB-1:0] prod [5][5];
	for (genvar r = 0; r < 5; r++) begin : g_row
		for (genvar c = 0; c < 5; c++) begin : g_col
			logic [PW-1:0] din;
			if (c == 4) begin : g_in
				assign din = v[r];
			end else begin : g_nb
				assign din = win[r][c+1];
			end
			gb5_cell #(.CB(CB)) u_cell (
				.clk(clk), .en(en), .shift(step_s1), .pix_in(din),
				.pix_q(win[r][c]), .coef(coef_q[tap_class(r, c)]),
				.prod_s1(prod[r][c])
			);
		end
	end
	// cells shift only on an item, products advance with the pipeline

	// stage 2: window updated; stage 3: products; stage 4: row sums; stage 5: out
	ctl_t ctl_s2, ctl_s3, ctl_s4;
	logic [CB-1:0] alpha_s3, alpha_s4, cen_s3 [3], cen_s4 [3];
	logic [SB-1:0] rsum_s4 [3][5];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0; ctl_s3 <= '0; ctl_s4 <= '0; out_valid <= 1'b0;
		end else if (en) begin
			ctl_s2 <= ctl_s1; ctl_s3 <= ctl_s2; ctl_s4 <= ctl_s3;
			out_valid <= ctl_s4.vld;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s3 <= win[2][2][3*CB +: CB];
			for (int ch = 0; ch < 3; ch++) cen_s3[ch] <= win[2][2][ch*CB +: CB];
			alpha_s4 <= alpha_s3;
			cen_s4 <= cen_s3;
			for (int ch = 0; ch < 3; ch++)
				for (int r = 0; r < 5; r++) begin
					rsum_s4[ch][r] <= SB'(prod[r][0][ch*PB +: PB]) +
						SB'(prod[r][1][ch*PB +: PB]) + SB'(prod[r][2][ch*PB +: PB]) +
						SB'(prod[r][3][ch*PB +: PB]) + SB'(prod[r][4][ch*PB +: PB]);
				end
		end
	end

	logic [CB-1:0] res [3];
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			logic [SB-1:0] tot;
			logic [SB-17:0] sh;
			tot = rsum_s4[ch][0] + rsum_s4[ch][1] + rsum_s4[ch][2] +
				rsum_s4[ch][3] + rsum_s4[ch][4] + SB'(32768);
			sh = tot[SB-1:16];
			if (!ctl_s4.blur) res[ch] = cen_s4[ch];
			else if (ctl_s4.border) res[ch] = '0;
			else if (sh > (SB-16)'(CMAX)) res[ch] = CMAX;
			else res[ch] = sh[CB-1:0];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_red <= 16'(res[0]); out_green <= 16'(res[1]);
			out_blue <= 16'(res[2]); out_alpha <= 16'(alpha_s4);
			last_pixel <= ctl_s4.last;
		end
	end
endmodule

// File: rtl/gb5_checker.sv
// Port-level checks for the blur core, bound to the top level.
// Depends on gaussian_blur_5x5_lower_region_core.
module gb5_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [15:0] out_red,
	input logic last_pixel
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(last_pixel))
		else $error("stalled result changed");
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output blocked");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("stall without pending result");
endmodule

bind gaussian_blur_5x5_lower_region_core gb5_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_red(out_red),
	.last_pixel(last_pixel)
);

// File: bench/gaussian_blur_5x5_lower_region_core_test.sv
// Self-checking bench for gaussian_blur_5x5_lower_region_core: whole frames at several
// register settings, random idling on both sides, results checked against a local predictor.
// Depends on gb5_pkg and the RTL of the blur core.
module gaussian_blur_5x5_lower_region_core_test import gb5_pkg::*;;
	localparam int LINE_DEPTH = 1024;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic        kind;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] alpha;
	} pixel_item_t;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] alpha;
		logic        last;
	} blur_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        func = FUNC_PIXEL;
	logic [15:0] in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] out_red, out_green, out_blue, out_alpha;
	logic        last_pixel;

	gaussian_blur_5x5_lower_region_core dut (.*);

	always #10 clk = ~clk;

	pixel_item_t  pixel_queue[$];
	blur_result_t expected_pixels[$];
	int  mismatches = 0;
	int  results_seen = 0;
	int  cycles = 0;
	bit  calm = 1'b0;

	// blur model state
	logic [15:0] regs [NUM_REGS];
	logic [63:0] line_mem [4*LINE_DEPTH];
	logic [63:0] window [5][5];
	int unsigned row_in, col_in, row_out, col_out;
	// distance class of a tap; class k uses register REG_C0 + k
	int unsigned dist_class [3][3] = '{'{0, 1, 3}, '{1, 2, 4}, '{3, 4, 5}};

	task automatic predict_item(input pixel_item_t it, output bit got, output bit is_last);
		int unsigned w, h, col, dr, dc;
		logic [63:0] pix, center;
		logic [63:0] v [5];
		longint unsigned acc;
		logic [15:0] res [3];
		bit tail, ready, blur, border;
		blur_result_t r;
		got = 0;
		is_last = 0;
		w = regs[REG_WIDTH];
		h = regs[REG_HEIGHT];
		if (w < 5) w = 5;
		if (w > LINE_DEPTH) w = LINE_DEPTH;
		if (h < 14) h = 14;
		tail = row_in >= h;
		// drop a flush while the frame still expects pixels
		if (!tail && it.kind == FUNC_FLUSH) return;
		pix = tail ? 64'd0 : {it.alpha, it.blue, it.green, it.red};
		col = col_in % LINE_DEPTH;
		for (int k = 0; k < 4; k++) v[k] = line_mem[((row_in + k) & 3) * LINE_DEPTH + col];
		v[4] = pix;
		line_mem[(row_in & 3) * LINE_DEPTH + col] = pix;
		for (int k = 0; k < 5; k++) begin
			for (int c = 0; c < 4; c++) window[k][c] = window[k][c+1];
			window[k][4] = v[k];
		end
		ready = row_in > 2 || (row_in == 2 && col_in >= 2);
		col_in++;
		if (col_in >= w) begin
			col_in = 0;
			row_in++;
		end
		if (!ready) return;
		center = window[2][2];
		blur = row_out >= h/2 - 5;
		border = col_out < 2 || col_out + 2 >= w || row_out < 2 || row_out + 2 >= h;
		for (int ch = 0; ch < 3; ch++) begin
			if (!blur) begin
				res[ch] = center[16*ch +: 16];
			end else if (border) begin
				res[ch] = '0;
			end else begin
				acc = 0;
				for (int k = 0; k < 5; k++) begin
					for (int c = 0; c < 5; c++) begin
						dr = k >= 2 ? k - 2 : 2 - k;
						dc = c >= 2 ? c - 2 : 2 - c;
						acc += longint'(regs[REG_C0 + dist_class[dr][dc]])
							* longint'(window[k][c][16*ch +: 16]);
					end
				end
				acc = (acc + 32768) >> 16;
				res[ch] = acc > 65535 ? 16'hFFFF : acc[15:0];
			end
		end
		is_last = row_out + 1 >= h && col_out + 1 >= w;
		r = '{red: res[0], green: res[1], blue: res[2], alpha: center[63:48], last: is_last};
		expected_pixels.push_back(r);
		got = 1;
		col_out++;
		if (col_out >= w) begin
			col_out = 0;
			row_out++;
		end
		if (is_last) begin
			row_in = 0; col_in = 0; row_out = 0; col_out = 0;
		end
	endtask

	// driver
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) pixel_queue.pop_front();
			if (!(in_valid && in_stall)) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pixel_queue.size() > 0) begin
					in_valid <= 1'b1;
					func <= pixel_queue[0].kind;
					in_red <= pixel_queue[0].red;
					in_green <= pixel_queue[0].green;
					in_blue <= pixel_queue[0].blue;
					in_alpha <= pixel_queue[0].alpha;
					if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int out_hold = 0;
	bit long_hold_done = 1'b0;
	always @(posedge clk) begin
		blur_result_t act, exp_r;
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("gaussian_blur_5x5_lower_region_core_test failed");
			$finish;
		end else if (arst_n) begin
			if (out_valid && !out_stall) begin
				act = '{out_red, out_green, out_blue, out_alpha, last_pixel};
				results_seen++;
				if (expected_pixels.size() == 0) begin
					mismatches++;
					$display("%0t: expected no result, got %h", $time, act);
				end else begin
					exp_r = expected_pixels.pop_front();
					if (act !== exp_r) begin
						mismatches++;
						$display("%0t: exp r=%h g=%h b=%h a=%h last=%b, got r=%h g=%h b=%h a=%h last=%b",
							$time, exp_r.red, exp_r.green, exp_r.blue, exp_r.alpha, exp_r.last,
							act.red, act.green, act.blue, act.alpha, act.last);
					end
				end
			end
			// hold off the output once for a long stretch so the input backs up
			if (!long_hold_done && results_seen >= 200) begin
				long_hold_done = 1'b1;
				out_hold = 400;
			end
			if (out_hold > 0) begin
				out_hold--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_hold = $urandom_range(0, 4);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic wait_idle();
		while (pixel_queue.size() > 0 || in_valid || expected_pixels.size() > 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_regs(input logic [15:0] vals [NUM_REGS]);
		for (int i = 0; i < NUM_REGS; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= i[2:0];
			cfg_data <= vals[i];
			regs[i] = vals[i] & (i == REG_WIDTH ? 16'h07FF : i == REG_HEIGHT ? 16'h1FFF : 16'hFFFF);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// data: 0 random, 1 all ones, 2 all zeros, 3 random extremes (each item all ones or all zeros)
	task automatic queue_frame(input int data_kind);
		pixel_item_t it;
		bit got, is_last, done;
		int h;
		h = regs[REG_HEIGHT] < 14 ? 14 : regs[REG_HEIGHT];
		done = 0;
		while (!done) begin
			if (row_in >= h) it.kind = $urandom_range(0, 1);
			else it.kind = $urandom_range(0, 15) == 0 ? FUNC_FLUSH : FUNC_PIXEL;
			case (data_kind)
				1: {it.red, it.green, it.blue, it.alpha} = '1;
				2: {it.red, it.green, it.blue, it.alpha} = '0;
				3: {it.red, it.green, it.blue, it.alpha} = $urandom_range(0, 1) ? '1 : '0;
				default: {it.red, it.green, it.blue, it.alpha} = {$urandom, $urandom};
			endcase
			pixel_queue.push_back(it);
			predict_item(it, got, is_last);
			if (got && is_last) done = 1;
		end
	endtask

	initial begin
		logic [15:0] setting [NUM_REGS];
		for (int i = 0; i < 4*LINE_DEPTH; i++) line_mem[i] = '0;
		window = '{default: '0};
		row_in = 0; col_in = 0; row_out = 0; col_out = 0;
		regs = '{16'd640, 16'd480, 16'd2837, 16'd2780, 16'd2725, 16'd2618, 16'd2567, 16'd2417};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// smallest frame, full weights: saturate
		setting = '{16'd5, 16'd14, '1, '1, '1, '1, '1, '1};
		write_regs(setting);
		queue_frame(1);
		queue_frame(3);
		wait_idle();
		// zero weights, sizes written below their floor
		setting = '{16'd0, 16'd0, '0, '0, '0, '0, '0, '0};
		write_regs(setting);
		queue_frame(0);
		wait_idle();
		setting = '{16'd9, 16'h1FFF, 16'd3000, 16'd3000, 16'd3000, 16'd3000, 16'd3000, 16'd3000};
		setting[REG_HEIGHT] = 16'd15;
		write_regs(setting);
		queue_frame(2);
		wait_idle();
		// random frames, small sizes
		for (int f = 0; f < 3; f++) begin
			setting[REG_WIDTH] = $urandom_range(5, 12);
			setting[REG_HEIGHT] = $urandom_range(14, 16);
			for (int i = REG_C0; i < NUM_REGS; i++)
				setting[i] = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
					: $urandom_range(1500, 3500);
			write_regs(setting);
			if (f == 2) calm = 1'b1;
			queue_frame(0);
			wait_idle();
		end
		if (mismatches == 0) begin
			$display("gaussian_blur_5x5_lower_region_core_test passed");
		end else begin
			$display("gaussian_blur_5x5_lower_region_core_test failed");
		end
		$finish;
	end
endmodule

// File: sim.f
rtl/gb5_pkg.sv
rtl/gb5_ram.sv
rtl/gb5_cell.sv
rtl/gaussian_blur_5x5_lower_region_core.sv
rtl/gb5_checker.sv
bench/gaussian_blur_5x5_lower_region_core_test.sv
